>>> rtl/hlp_pkg.sv
// ============================================================================
// hlp_pkg: shared definitions for the linear-probe hash table
// Slot layout, tag and command codes, and sizing constants.
// ============================================================================
package hlp_pkg;

    // Slot count must be a power of two: the home slot is the low hash bits.
    localparam int unsigned TABLE_SLOTS = 1024;
    localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W       = IDX_W + 1;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned HASH_W = 32;
    localparam int unsigned DATA_W = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam idx_t LAST_IDX  = idx_t'(TABLE_SLOTS - 1);
    localparam cnt_t OCC_LIMIT = cnt_t'(TABLE_SLOTS / 2);

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_USED  = 2'd1,
        TAG_GRAVE = 2'd2
    } tag_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    typedef struct packed {
        tag_t              tag;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [DATA_W-1:0] data;
    } slot_t;

    // Verdict of the slot comparator for one probed slot.
    typedef struct packed {
        logic hit;
        logic empty;
    } probe_t;

endpackage

>>> rtl/hlp_ifs.sv
// ============================================================================
// hlp_ifs: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface hlp_req_if;
    logic                      valid;
    logic                      ready;
    logic [hlp_pkg::CMD_W-1:0]  cmd;
    logic [hlp_pkg::KEY_W-1:0]  key;
    logic [hlp_pkg::HASH_W-1:0] hash;
    logic [hlp_pkg::DATA_W-1:0] data;

    modport source (output valid, cmd, key, hash, data, input ready);
    modport sink   (input valid, cmd, key, hash, data, output ready);
endinterface

interface hlp_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [hlp_pkg::DATA_W-1:0] result_data;
    logic                      status;

    modport source (output valid, found, result_data, status, input ready);
    modport sink   (input valid, found, result_data, status, output ready);
endinterface

>>> rtl/hlp_slot_mem.sv
// ============================================================================
// hlp_slot_mem: slot storage
// One write port and one read port with registered read data; no reset.
// ============================================================================
module hlp_slot_mem (
    input  logic           clk,
    input  logic           we,
    input  hlp_pkg::idx_t  waddr,
    input  hlp_pkg::slot_t wdata,
    input  hlp_pkg::idx_t  raddr,
    output hlp_pkg::slot_t rdata
);

    hlp_pkg::slot_t mem [hlp_pkg::TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/hlp_slot_cmp.sv
// ============================================================================
// hlp_slot_cmp: slot comparator
// Classifies one probed slot as empty, a key match, or something to skip.
// ============================================================================
module hlp_slot_cmp (
    input  hlp_pkg::slot_t              entry,
    input  logic [hlp_pkg::KEY_W-1:0]   key,
    input  logic [hlp_pkg::HASH_W-1:0]  hash,
    output hlp_pkg::probe_t             verdict
);

    // A tombstone never matches; only live slots compare hash and key.
    always_comb
    begin
        verdict.empty = (entry.tag == hlp_pkg::TAG_EMPTY);
        verdict.hit   = (entry.tag == hlp_pkg::TAG_USED) &&
                        (entry.hash == hash) && (entry.key == key);
    end

endmodule

>>> rtl/hash_table_linear_probe.sv
// ============================================================================
// hash_table_linear_probe: open-addressed hash table with linear probing
// Lookup, insert-if-absent, insert-or-replace and remove over a slot memory.
// ============================================================================
// Usage. Requests arrive on the req channel (cmd, key, hash, data) and
// one response per request leaves on the rsp channel (found, result_data,
// status). Each channel moves an item in one transfer when valid and ready
// are both high.
//
// After reset is released the block runs a clearing pass that marks every
// slot empty, one slot per cycle, during which req.ready stays low.
// Afterwards req.ready is high whenever the sequencer is idle.
//
// Timing. A transferred request is registered and its home slot is read
// in ST_READ; the registered slot is compared in ST_CHECK, which also
// fetches every further slot visited, since the single memory read port
// delivers one slot per cycle to the shared comparator. The response
// sits in an output register that is loaded as the sequencer returns to
// idle, so the next request is taken while an earlier response still
// waits. If that register is still full when a probe ends, the sequencer
// holds its final slot, without writing, until the receiver takes the
// waiting response.
// ============================================================================
module hash_table_linear_probe (
    input logic      clk,
    input logic      rst_n,
    hlp_req_if.sink  req,
    hlp_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    state_t                     state_reg, state_next;
    hlp_pkg::idx_t              clr_reg, clr_next;
    hlp_pkg::idx_t              pos_reg, pos_next;
    hlp_pkg::idx_t              step_reg, step_next;
    hlp_pkg::cnt_t              occ_reg, occ_next;
    hlp_pkg::cmd_t              cmd_reg, cmd_next;
    logic [hlp_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [hlp_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [hlp_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg, found_next;
    logic [hlp_pkg::DATA_W-1:0] res_reg, res_next;
    logic                       status_reg, status_next;

    logic            mem_we;
    hlp_pkg::idx_t   mem_waddr;
    hlp_pkg::slot_t  wr_entry;
    hlp_pkg::idx_t   mem_raddr;
    hlp_pkg::slot_t  rd_entry;
    hlp_pkg::probe_t verdict;
    logic            out_free;
    logic            keep_going;

    hlp_slot_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_entry),
        .raddr (mem_raddr),
        .rdata (rd_entry)
    );

    hlp_slot_cmp u_cmp (
        .entry   (rd_entry),
        .key     (key_reg),
        .hash    (hash_reg),
        .verdict (verdict)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.result_data = res_reg;
    assign rsp.status      = status_reg;

    // The response register can take a new result when it is empty or is
    // being drained in this cycle.
    assign out_free = !out_valid_reg || rsp.ready;

    // The walk goes on past tombstones and other keys, but never visits more
    // than every slot once.
    assign keep_going = !verdict.hit && !verdict.empty && (step_reg != hlp_pkg::LAST_IDX);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        occ_next       = occ_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_raddr = pos_reg;
        wr_entry  = rd_entry;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Mark one slot empty per cycle; the other fields are cleared as well.
                mem_we       = 1'b1;
                mem_waddr    = clr_reg;
                wr_entry     = '0;
                wr_entry.tag = hlp_pkg::TAG_EMPTY;
                clr_next     = hlp_pkg::idx_t'(clr_reg + 1'b1);
                if (clr_reg == hlp_pkg::LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = hlp_pkg::cmd_t'(req.cmd);
                    key_next   = req.key;
                    hash_next  = req.hash;
                    data_next  = req.data;
                    pos_next   = req.hash[hlp_pkg::IDX_W-1:0];
                    step_next  = '0;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // The home slot is being read; its contents arrive next cycle.
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (keep_going)
                begin
                    // Fetch the following slot straight away, wrapping at the end.
                    pos_next  = hlp_pkg::idx_t'(pos_reg + 1'b1);
                    step_next = hlp_pkg::idx_t'(step_reg + 1'b1);
                    mem_raddr = pos_next;
                end
                else if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    found_next     = verdict.hit;
                    res_next       = '0;
                    status_next    = 1'b0;
                    if (verdict.hit)
                    begin
                        case (cmd_reg) inside
                            hlp_pkg::CMD_LOOKUP, hlp_pkg::CMD_INSERT:
                            begin
                                res_next = rd_entry.data;
                            end
                            hlp_pkg::CMD_REPLACE:
                            begin
                                res_next      = rd_entry.data;
                                mem_we        = 1'b1;
                                wr_entry.data = data_reg;
                            end
                            default:
                            begin
                                // Remove leaves a tombstone so later keys stay reachable.
                                mem_we        = 1'b1;
                                wr_entry.tag  = hlp_pkg::TAG_GRAVE;
                                wr_entry.hash = '0;
                                wr_entry.data = '0;
                            end
                        endcase
                    end
                    else if ((cmd_reg == hlp_pkg::CMD_INSERT) ||
                             (cmd_reg == hlp_pkg::CMD_REPLACE))
                    begin
                        if ((occ_reg > hlp_pkg::OCC_LIMIT) || !verdict.empty)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            wr_entry.tag  = hlp_pkg::TAG_USED;
                            wr_entry.key  = key_reg;
                            wr_entry.hash = hash_reg;
                            wr_entry.data = data_reg;
                            occ_next      = hlp_pkg::cnt_t'(occ_reg + 1'b1);
                            res_next      = data_reg;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        hash_reg   <= hash_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // The occupancy count cannot run past one beyond the half-full limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= hlp_pkg::cnt_t'(hlp_pkg::OCC_LIMIT + 1'b1))
        else $error("occupancy count exceeded its bound");

    // The count only moves together with a write that makes a slot live.
    assert property (@(posedge clk) disable iff (!rst_n)
        (occ_next != occ_reg) |-> (mem_we && (wr_entry.tag == hlp_pkg::TAG_USED)))
        else $error("occupancy changed without a new live slot");

    // A probe never writes the table while the response register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == ST_CHECK)) |-> out_free)
        else $error("slot written while the response register was full");

    // An accepted request always starts with a read of its home slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=>
            ((state_reg == ST_READ) && (pos_reg == $past(req.hash[hlp_pkg::IDX_W-1:0]))))
        else $error("probe did not start at the home slot");

    // A new response is loaded only on the way back to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg == ST_IDLE) && ($past(state_reg) == ST_CHECK))
        else $error("response appeared outside the end of a probe");

endmodule
